### rtl/core/sowl_pkg.sv
// shared types and constants for the sort block with skip and limit
package sowl_pkg;

  // configuration register layout
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  // width for count arithmetic, one bit above the register width
  localparam int unsigned ARITH_W   = CFG_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NO_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SKIP_COUNT  = 2'd2;

  localparam logic             NO_LIMIT_RST    = 1'b1;
  localparam logic [CFG_W-1:0] LIMIT_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] SKIP_COUNT_RST  = 7'd0;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_FLUSH  = 2'd3
  } cell_cmd_t;

  // control states, one-hot
  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } ctrl_state_t;

endpackage

### rtl/core/sowl_cell.sv
// one cell of the sorted insertion chain: holds one record
module sowl_cell #(
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sowl_pkg::cell_cmd_t      cmd,
  input  logic [KEY_WIDTH-1:0]     new_key,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload,
  // neighbor toward the head (smaller keys)
  input  logic                     up_gt,
  input  logic                     up_valid,
  input  logic [KEY_WIDTH-1:0]     up_key,
  input  logic [PAYLOAD_WIDTH-1:0] up_payload,
  // neighbor toward the tail (larger keys)
  input  logic                     dn_valid,
  input  logic [KEY_WIDTH-1:0]     dn_key,
  input  logic [PAYLOAD_WIDTH-1:0] dn_payload,
  output logic                     gt,
  output logic                     valid,
  output logic [KEY_WIDTH-1:0]     key,
  output logic [PAYLOAD_WIDTH-1:0] payload
);
  import sowl_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0]     key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;

  // empty cells sort after everything; strict compare keeps equal keys in arrival order
  assign gt = !valid_r || (key_r > new_key);

  // next contents of the cell
  always_comb begin
    valid_nxt   = valid_r;
    key_nxt     = key_r;
    payload_nxt = payload_r;
    case (cmd)
      CMD_INSERT: begin
        if (gt) begin
          if (up_gt) begin
            valid_nxt   = up_valid;
            key_nxt     = up_key;
            payload_nxt = up_payload;
          end else begin
            valid_nxt   = 1'b1;
            key_nxt     = new_key;
            payload_nxt = new_payload;
          end
        end
      end
      CMD_POP: begin
        valid_nxt   = dn_valid;
        key_nxt     = dn_key;
        payload_nxt = dn_payload;
      end
      CMD_FLUSH: begin
        valid_nxt = 1'b0;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // record contents
  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign valid   = valid_r;
  assign key     = key_r;
  assign payload = payload_r;

endmodule

### rtl/core/sort_with_offset_and_limit_top.sv
// top level: insertion chain of cells with load / drain control and output register
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+--------------------------------------------
//  in_     | input     | in_valid/in_ready  | in_sort_key, in_payload, in_last_record
//  out_    | output    | out_valid/out_ready| out_key, out_payload, out_final_result,
//          |           |                    | out_truncated
//  cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata (no_limit, limit, skip)
//
// loading takes one record per cycle; every cell compares against the record on the
// shared insertion bus and shifts in the same cycle
// after the last record: the chain head is popped once per skipped record (none when
// the set emits nothing), then one result per cycle while out_ready holds, then a
// flush empties the chain; in_ready is low meanwhile
// a stalled output holds the head of the chain; reset empties the chain and loads
// the register defaults
module sort_with_offset_and_limit_top #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input transfer
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [KEY_WIDTH-1:0]                in_sort_key,
  input  logic [PAYLOAD_WIDTH-1:0]            in_payload,
  input  logic                                in_last_record,
  // result transfer
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [KEY_WIDTH-1:0]                out_key,
  output logic [PAYLOAD_WIDTH-1:0]            out_payload,
  output logic                                out_final_result,
  output logic                                out_truncated,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [sowl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sowl_pkg::CFG_W-1:0]          cfg_wdata
);
  import sowl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // configuration registers
  logic             no_limit_r;
  logic [CFG_W-1:0] limit_count_r;
  logic [CFG_W-1:0] skip_count_r;

  // control state
  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic             set_trunc_r, set_trunc_nxt;
  logic [CNT_W-1:0] skip_left_r, skip_left_nxt;
  logic [CNT_W-1:0] emit_left_r, emit_left_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [KEY_WIDTH-1:0]     out_key_r, out_key_nxt;
  logic [PAYLOAD_WIDTH-1:0] out_payload_r, out_payload_nxt;
  logic                     out_final_r, out_final_nxt;
  logic                     out_trunc_r, out_trunc_nxt;

  cell_cmd_t cmd;

  // chain links
  logic                     gt_w      [CAPACITY];
  logic                     valid_w   [CAPACITY];
  logic [KEY_WIDTH-1:0]     key_w     [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] payload_w [CAPACITY];

  // set bounds at the last record
  logic               in_xfer;
  logic               full;
  logic [CNT_W-1:0]   n_new;
  logic [ARITH_W-1:0] n_ext, skip_ext, limit_ext, room, emit_sel;
  logic               load_out;

  assign in_xfer  = in_valid && in_ready;
  assign in_ready = (state_r == ST_LOAD);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign n_new    = full ? count_r : count_r + CNT_W'(1);
  assign n_ext    = ARITH_W'(n_new);
  assign skip_ext = ARITH_W'(skip_count_r);
  assign limit_ext = ARITH_W'(limit_count_r);
  assign room     = n_ext - skip_ext;

  // number of results for the set
  always_comb begin
    if (skip_ext >= n_ext) begin
      emit_sel = '0;
    end else if (no_limit_r || (limit_ext >= room)) begin
      emit_sel = room;
    end else begin
      emit_sel = limit_ext;
    end
  end

  assign load_out = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_limit_r    <= NO_LIMIT_RST;
      limit_count_r <= LIMIT_COUNT_RST;
      skip_count_r  <= SKIP_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_NO_LIMIT:    no_limit_r    <= cfg_wdata[0];
        CFG_IDX_LIMIT_COUNT: limit_count_r <= cfg_wdata;
        CFG_IDX_SKIP_COUNT:  skip_count_r  <= cfg_wdata;
        default: begin
          no_limit_r <= no_limit_r;
        end
      endcase
    end
  end

  // load / drain sequencing
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    overflow_nxt    = overflow_r;
    set_trunc_nxt   = set_trunc_r;
    skip_left_nxt   = skip_left_r;
    emit_left_nxt   = emit_left_r;
    cmd             = CMD_HOLD;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_key_nxt     = out_key_r;
    out_payload_nxt = out_payload_r;
    out_final_nxt   = out_final_r;
    out_trunc_nxt   = out_trunc_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            overflow_nxt = 1'b1;
          end else begin
            cmd       = CMD_INSERT;
            count_nxt = n_new;
          end
          if (in_last_record) begin
            state_nxt     = ST_DRAIN;
            set_trunc_nxt = overflow_r || full;
            emit_left_nxt = emit_sel[CNT_W-1:0];
            skip_left_nxt = (emit_sel == '0) ? '0 : skip_count_r[CNT_W-1:0];
          end
        end
      end
      ST_DRAIN: begin
        if (skip_left_r != '0) begin
          cmd           = CMD_POP;
          skip_left_nxt = skip_left_r - CNT_W'(1);
        end else if (emit_left_r != '0) begin
          if (load_out) begin
            cmd             = CMD_POP;
            emit_left_nxt   = emit_left_r - CNT_W'(1);
            out_valid_nxt   = 1'b1;
            out_key_nxt     = key_w[0];
            out_payload_nxt = payload_w[0];
            out_final_nxt   = (emit_left_r == CNT_W'(1));
            out_trunc_nxt   = set_trunc_r;
          end
        end else begin
          cmd          = CMD_FLUSH;
          count_nxt    = '0;
          overflow_nxt = 1'b0;
          state_nxt    = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      set_trunc_r <= 1'b0;
      skip_left_r <= '0;
      emit_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      set_trunc_r <= set_trunc_nxt;
      skip_left_r <= skip_left_nxt;
      emit_left_r <= emit_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_key_r     <= out_key_nxt;
    out_payload_r <= out_payload_nxt;
    out_final_r   <= out_final_nxt;
    out_trunc_r   <= out_trunc_nxt;
  end

  // the cell chain, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     up_gt, up_valid, dn_valid;
    logic [KEY_WIDTH-1:0]     up_key, dn_key;
    logic [PAYLOAD_WIDTH-1:0] up_payload, dn_payload;

    if (i == 0) begin : g_head
      assign up_gt      = 1'b0;
      assign up_valid   = 1'b0;
      assign up_key     = '0;
      assign up_payload = '0;
    end else begin : g_mid
      assign up_gt      = gt_w[i-1];
      assign up_valid   = valid_w[i-1];
      assign up_key     = key_w[i-1];
      assign up_payload = payload_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign dn_valid   = 1'b0;
      assign dn_key     = '0;
      assign dn_payload = '0;
    end else begin : g_body
      assign dn_valid   = valid_w[i+1];
      assign dn_key     = key_w[i+1];
      assign dn_payload = payload_w[i+1];
    end

    sowl_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .new_key     (in_sort_key),
      .new_payload (in_payload),
      .up_gt       (up_gt),
      .up_valid    (up_valid),
      .up_key      (up_key),
      .up_payload  (up_payload),
      .dn_valid    (dn_valid),
      .dn_key      (dn_key),
      .dn_payload  (dn_payload),
      .gt          (gt_w[i]),
      .valid       (valid_w[i]),
      .key         (key_w[i]),
      .payload     (payload_w[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_key          = out_key_r;
  assign out_payload      = out_payload_r;
  assign out_final_result = out_final_r;
  assign out_truncated    = out_trunc_r;

endmodule

### rtl/core/sowl_checker.sv
// port-level checks for the sort block, bound to the top level
module sowl_checker #(
  parameter int unsigned KEY_WIDTH     = 32,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_last_record,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [KEY_WIDTH-1:0]     out_key,
  input logic [PAYLOAD_WIDTH-1:0] out_payload,
  input logic                     out_final_result
);

  // a stalled result holds its key and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_payload))
    else $error("stalled result changed");

  // the last record of a set stops intake until the set is drained
  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_record |=> !in_ready)
    else $error("input still ready after last record");

  // a new result only appears while intake is closed
  a_result_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while loading");

  // results of a set follow back to back until the final one
  a_no_gap_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_result |=> out_valid)
    else $error("gap inside a result set");

endmodule

bind sort_with_offset_and_limit_top sowl_checker #(
  .KEY_WIDTH     (KEY_WIDTH),
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_sowl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last_record   (in_last_record),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_key          (out_key),
  .out_payload      (out_payload),
  .out_final_result (out_final_result)
);
